### hw/rtl/stopwatch_tenths_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Stopwatch assertion macros
// Shared assertion forms for the stopwatch blocks. Each macro expects signals
// named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef STOPWATCH_TENTHS_INTERPOLATOR_ASSERT_SVH
`define STOPWATCH_TENTHS_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWTI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWTI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/swti_pkg.sv
// ----------------------------------------------------------------------------
// Stopwatch package
// Types, constants and the day-wrapped difference shared by the stopwatch.
// ----------------------------------------------------------------------------
package swti_pkg;

  localparam logic [16:0] DAY_SECONDS   = 17'd86400;
  localparam logic [19:0] DAY_TENTHS    = 20'd864000;
  localparam logic [15:0] DELAY_RESET   = 16'd2200;
  localparam logic [9:0]  STEP_RESET    = 10'd200;
  localparam logic [3:0]  TICK_TOP      = 4'd9;
  localparam int          HOUR_TENTHS   = 36000;
  localparam int          MINUTE_TENTHS = 600;
  localparam int          SECOND_TENTHS = 10;
  localparam int          HOURS_PER_DAY = 24;
  localparam int          MINUTES_PER_HOUR = 60;
  localparam logic [16:0] DIV10_MUL     = 17'd205;
  localparam int          DIV10_SHIFT   = 11;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_LAP   = 2'd2
  } mode_t;

  typedef struct packed {
    logic        moved;
    logic        b_valid;
    logic        active;
    logic [3:0]  tick;
    logic [19:0] now_t;
    logic [19:0] start_t;
    logic [19:0] lap;
    logic [15:0] delay;
  } state_view_t;

  typedef struct packed {
    logic [19:0] tenths;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  secs;
    logic [3:0]  digit;
  } split_t;

  // Time from origin to stop plus extra tenths, wrapped to one day.
  function automatic logic [19:0] span(logic [19:0] stop, logic [19:0] origin,
                                       logic [3:0] extra);
    logic [20:0] sum;
    sum = {1'b0, stop} + {1'b0, DAY_TENTHS} - {1'b0, origin} + {17'd0, extra};
    if (sum >= {1'b0, DAY_TENTHS}) begin
      sum = sum - {1'b0, DAY_TENTHS};
    end
    return sum[19:0];
  endfunction

endpackage

### hw/rtl/swti_in_if.sv
// ----------------------------------------------------------------------------
// Stopwatch event channel
// Valid/ready channel carrying one tick or key event per beat.
// ----------------------------------------------------------------------------
interface swti_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [16:0] rtc_seconds;

  modport source (output valid, mode, rtc_seconds, input ready);
  modport sink (input valid, mode, rtc_seconds, output ready);
endinterface

### hw/rtl/swti_out_if.sv
// ----------------------------------------------------------------------------
// Stopwatch status channel
// Valid/ready channel carrying elapsed time, lap time and delay per beat.
// ----------------------------------------------------------------------------
interface swti_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] elapsed_tenths;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  secs;
  logic [3:0]  tenth_digit;
  logic [19:0] lap_tenths;
  logic [4:0]  lap_hours;
  logic [5:0]  lap_minutes;
  logic [5:0]  lap_secs;
  logic [3:0]  lap_tenth_digit;
  logic        running;
  logic [15:0] tick_delay_ms;

  modport source (
    output valid, elapsed_tenths, hours, minutes, secs, tenth_digit,
           lap_tenths, lap_hours, lap_minutes, lap_secs, lap_tenth_digit,
           running, tick_delay_ms,
    input  ready
  );
  modport sink (
    input  valid, elapsed_tenths, hours, minutes, secs, tenth_digit,
           lap_tenths, lap_hours, lap_minutes, lap_secs, lap_tenth_digit,
           running, tick_delay_ms,
    output ready
  );
endinterface

### hw/rtl/swti_core.sv
// ----------------------------------------------------------------------------
// Stopwatch core
// Input register and the registered update of the stopwatch state.
// ----------------------------------------------------------------------------
module swti_core
  import swti_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  swti_in_if.sink      events,
  input  logic         cfg_we,
  input  logic [9:0]   cfg_wdata,
  input  logic         b_ready,
  output state_view_t  view
);

  logic        a_valid;
  logic [1:0]  mode_r;
  logic [16:0] rtc_r;
  logic        b_valid;

  logic        active;
  logic        first_second;
  logic [3:0]  tick;
  logic [19:0] last_t;
  logic [19:0] start_t;
  logic [19:0] now_t;
  logic [19:0] lap;
  logic [15:0] delay;
  logic [9:0]  delay_step;

  logic        active_next;
  logic        first_second_next;
  logic [3:0]  tick_next;
  logic [19:0] last_t_next;
  logic [19:0] start_t_next;
  logic [19:0] now_t_next;
  logic [19:0] lap_next;
  logic [15:0] delay_next;

  logic        b_open;
  logic        a_open;
  logic        moved;

  logic [16:0] rtc_sec;
  logic [19:0] rtc_t;
  logic [3:0]  tick_inc;
  logic        grow;
  logic [3:0]  tick_sat;
  logic [3:0]  gap;
  logic [13:0] shrink_amt;
  logic [16:0] grow_sum;
  logic [15:0] grown;
  logic [15:0] shrunk;
  logic [19:0] start_sum;
  logic [19:0] start_adj;

  assign b_open       = !b_valid || b_ready;
  assign a_open       = !a_valid || b_open;
  assign moved        = a_valid && b_open;
  assign events.ready = a_open;

  assign rtc_sec    = (rtc_r >= DAY_SECONDS) ? rtc_r - DAY_SECONDS : rtc_r;
  assign rtc_t      = ({3'd0, rtc_sec} << 3) + ({3'd0, rtc_sec} << 1);
  assign tick_inc   = tick + 4'd1;
  assign grow       = tick_inc > TICK_TOP;
  assign tick_sat   = grow ? TICK_TOP : tick_inc;
  assign gap        = TICK_TOP - tick_sat;
  assign shrink_amt = {4'd0, delay_step} * {10'd0, gap};
  assign grow_sum   = {1'b0, delay} + {7'd0, delay_step};
  assign grown      = grow_sum[16] ? 16'hFFFF : grow_sum[15:0];
  assign shrunk     = ({2'd0, shrink_amt} >= delay) ? 16'd0 : delay - {2'd0, shrink_amt};
  assign start_sum  = start_t + {16'd0, gap};
  assign start_adj  = (start_sum >= DAY_TENTHS) ? start_sum - DAY_TENTHS : start_sum;

  always_comb begin
    active_next       = active;
    first_second_next = first_second;
    tick_next         = tick;
    last_t_next       = last_t;
    start_t_next      = start_t;
    now_t_next        = now_t;
    lap_next          = lap;
    delay_next        = delay;
    case (mode_t'(mode_r))
      MODE_TICK: begin
        if (active) begin
          now_t_next = rtc_t;
          tick_next  = tick_sat;
          if (grow) begin
            delay_next = grown;
          end
          if (rtc_t != last_t) begin
            if (first_second) begin
              start_t_next      = start_adj;
              first_second_next = 1'b0;
            end else if (tick_sat < TICK_TOP) begin
              delay_next = shrunk;
            end
            tick_next   = 4'd0;
            last_t_next = rtc_t;
          end
        end
      end
      MODE_PRESS: begin
        if (!active) begin
          first_second_next = 1'b1;
          tick_next         = 4'd0;
          start_t_next      = rtc_t;
          last_t_next       = rtc_t;
          now_t_next        = rtc_t;
        end
        active_next = !active;
      end
      MODE_LAP: begin
        if (active) begin
          lap_next = span(last_t, start_t, tick);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_open) begin
      mode_r <= events.mode;
      rtc_r  <= events.rtc_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      active       <= 1'b0;
      first_second <= 1'b0;
      tick         <= 4'd0;
      last_t       <= 20'd0;
      start_t      <= 20'd0;
      now_t        <= 20'd0;
      lap          <= 20'd0;
      delay        <= DELAY_RESET;
      delay_step   <= STEP_RESET;
    end else begin
      if (a_open) begin
        a_valid <= events.valid;
      end
      if (b_open) begin
        b_valid <= a_valid;
      end
      if (moved) begin
        active       <= active_next;
        first_second <= first_second_next;
        tick         <= tick_next;
        last_t       <= last_t_next;
        start_t      <= start_t_next;
        now_t        <= now_t_next;
        lap          <= lap_next;
        delay        <= delay_next;
      end
      if (cfg_we) begin
        delay_step <= cfg_wdata;
      end
    end
  end

  assign view.moved   = moved;
  assign view.b_valid = b_valid;
  assign view.active  = active;
  assign view.tick    = tick;
  assign view.now_t   = now_t;
  assign view.start_t = start_t;
  assign view.lap     = lap;
  assign view.delay   = delay;

endmodule

### hw/rtl/swti_split.sv
// ----------------------------------------------------------------------------
// Stopwatch time splitter
// Two-stage split of a tenths count into hours, minutes, seconds and tenths.
// ----------------------------------------------------------------------------
module swti_split
  import swti_pkg::*;
(
  input  logic        clk,
  input  logic        load_hours,
  input  logic        load_rest,
  input  logic [19:0] tenths,
  output split_t      parts
);

  logic [19:0] t1;
  logic [4:0]  h1;
  logic [15:0] rem1;

  logic [4:0]  hours_c;
  logic [19:0] hour_base;
  logic [5:0]  minutes_c;
  logic [15:0] minute_base;
  logic [9:0]  rem2;
  logic [16:0] prod;
  logic [5:0]  secs_c;
  logic [3:0]  digit_c;

  // Each threshold is compared in parallel; the last one met wins.
  always_comb begin
    hours_c   = 5'd0;
    hour_base = 20'd0;
    for (int k = 1; k < HOURS_PER_DAY; k++) begin
      if (tenths >= 20'(k * HOUR_TENTHS)) begin
        hours_c   = 5'(k);
        hour_base = 20'(k * HOUR_TENTHS);
      end
    end
  end

  always_comb begin
    minutes_c   = 6'd0;
    minute_base = 16'd0;
    for (int k = 1; k < MINUTES_PER_HOUR; k++) begin
      if (rem1 >= 16'(k * MINUTE_TENTHS)) begin
        minutes_c   = 6'(k);
        minute_base = 16'(k * MINUTE_TENTHS);
      end
    end
  end

  assign rem2    = 10'(rem1 - minute_base);
  assign prod    = {7'd0, rem2} * DIV10_MUL;
  assign secs_c  = prod[DIV10_SHIFT +: 6];
  assign digit_c = 4'(rem2 - {4'd0, secs_c} * 10'(SECOND_TENTHS));

  always_ff @(posedge clk) begin
    if (load_hours) begin
      t1   <= tenths;
      h1   <= hours_c;
      rem1 <= 16'(tenths - hour_base);
    end
    if (load_rest) begin
      parts.tenths  <= t1;
      parts.hours   <= h1;
      parts.minutes <= minutes_c;
      parts.secs    <= secs_c;
      parts.digit   <= digit_c;
    end
  end

endmodule

### hw/rtl/stopwatch_tenths_interpolator.sv
// ----------------------------------------------------------------------------
// Stopwatch with tenths interpolation and lap
// Takes one event beat per cycle (refresh tick, start/stop press, lap press or
// an unused code that changes nothing) while the status side is not stalled,
// and returns one status beat per event through its registered stages.
// Each event's state update is computed combinationally, and that update sets
// the rate. Elapsed and lap times are then split into hours, minutes, seconds
// and tenths over two registered stages. The delay step register may be
// written at any time the block is idle and takes effect on the next event.
// ----------------------------------------------------------------------------
module stopwatch_tenths_interpolator
  import swti_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  swti_in_if.sink     events,
  swti_out_if.source  status,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);

`include "stopwatch_tenths_interpolator_assert.svh"

  state_view_t view;

  logic        c_valid;
  logic        d_valid;
  logic        e_valid;
  logic        c_open;
  logic        d_open;
  logic        e_open;

  logic [19:0] c_elapsed;
  logic [19:0] c_lap;
  logic        c_active;
  logic [15:0] c_delay;
  logic        d_active;
  logic [15:0] d_delay;
  logic        e_active;
  logic [15:0] e_delay;

  split_t      elapsed_parts;
  split_t      lap_parts;
  logic [19:0] elapsed_back;
  logic [19:0] lap_back;

  assign e_open = !e_valid || status.ready;
  assign d_open = !d_valid || e_open;
  assign c_open = !c_valid || d_open;

  swti_core u_core (
    .clk       (clk),
    .rst       (rst),
    .events    (events),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .b_ready   (c_open),
    .view      (view)
  );

  // The state registers hold the result of the event in stage B until it moves on.
  always_ff @(posedge clk) begin
    if (c_open) begin
      c_elapsed <= span(view.now_t, view.start_t, view.tick);
      c_lap     <= view.lap;
      c_active  <= view.active;
      c_delay   <= view.delay;
    end
    if (d_open) begin
      d_active <= c_active;
      d_delay  <= c_delay;
    end
    if (e_open) begin
      e_active <= d_active;
      e_delay  <= d_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      if (c_open) begin
        c_valid <= view.b_valid;
      end
      if (d_open) begin
        d_valid <= c_valid;
      end
      if (e_open) begin
        e_valid <= d_valid;
      end
    end
  end

  swti_split u_split_elapsed (
    .clk        (clk),
    .load_hours (d_open),
    .load_rest  (e_open),
    .tenths     (c_elapsed),
    .parts      (elapsed_parts)
  );

  swti_split u_split_lap (
    .clk        (clk),
    .load_hours (d_open),
    .load_rest  (e_open),
    .tenths     (c_lap),
    .parts      (lap_parts)
  );

  assign status.valid           = e_valid;
  assign status.elapsed_tenths  = elapsed_parts.tenths;
  assign status.hours           = elapsed_parts.hours;
  assign status.minutes         = elapsed_parts.minutes;
  assign status.secs            = elapsed_parts.secs;
  assign status.tenth_digit     = elapsed_parts.digit;
  assign status.lap_tenths      = lap_parts.tenths;
  assign status.lap_hours       = lap_parts.hours;
  assign status.lap_minutes     = lap_parts.minutes;
  assign status.lap_secs        = lap_parts.secs;
  assign status.lap_tenth_digit = lap_parts.digit;
  assign status.running         = e_active;
  assign status.tick_delay_ms   = e_delay;

  // Rebuild each time from its digits to check the splitters.
  assign elapsed_back = 20'(elapsed_parts.hours) * 20'(HOUR_TENTHS)
                      + 20'(elapsed_parts.minutes) * 20'(MINUTE_TENTHS)
                      + 20'(elapsed_parts.secs) * 20'(SECOND_TENTHS)
                      + 20'(elapsed_parts.digit);
  assign lap_back     = 20'(lap_parts.hours) * 20'(HOUR_TENTHS)
                      + 20'(lap_parts.minutes) * 20'(MINUTE_TENTHS)
                      + 20'(lap_parts.secs) * 20'(SECOND_TENTHS)
                      + 20'(lap_parts.digit);

  `SWTI_ASSERT_NOW(a_elapsed_split, e_valid, (elapsed_back == elapsed_parts.tenths) && (elapsed_parts.digit < 4'(SECOND_TENTHS)) && (elapsed_parts.secs < 6'd60) && (elapsed_parts.minutes < 6'(MINUTES_PER_HOUR)), "Elapsed digits do not match elapsed tenths.")
  `SWTI_ASSERT_NOW(a_lap_split, e_valid, (lap_back == lap_parts.tenths) && (lap_parts.digit < 4'(SECOND_TENTHS)) && (lap_parts.secs < 6'd60) && (lap_parts.minutes < 6'(MINUTES_PER_HOUR)), "Lap digits do not match lap tenths.")
  `SWTI_ASSERT_NEXT(a_delay_hold, !view.moved, $stable(view.delay) && $stable(view.lap), "Stopwatch state changed without an event moving.")

endmodule

### tb/tb_stopwatch_tenths_interpolator.sv
// ----------------------------------------------------------------------------
// Stopwatch tenths interpolator testbench
// Drives tick, start/stop, lap and unused events with random gaps and status
// stalls. A behavioral predictor computes every status beat, and each beat is
// compared field by field as it arrives. Directed cases cover the stopped
// state, the realignment on the first change of second, delay saturation and
// out-of-range clock values. Random sessions under several delay steps follow.
// ----------------------------------------------------------------------------
module tb_stopwatch_tenths_interpolator
  import swti_pkg::*;
();

  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [19:0] tenths;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  secs;
    logic [3:0]  digit;
  } face_t;

  typedef struct packed {
    face_t       run;
    face_t       lap;
    logic        running;
    logic [15:0] delay;
  } status_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [9:0] cfg_wdata;

  swti_in_if  events_if ();
  swti_out_if status_if ();

  stopwatch_tenths_interpolator DUT (
    .clk       (clk),
    .rst       (rst),
    .events    (events_if),
    .status    (status_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  logic        sw_active;
  logic        sw_first;
  logic [3:0]  sw_tick;
  logic [19:0] sw_last;
  logic [19:0] sw_start;
  logic [19:0] sw_now;
  logic [19:0] sw_lap;
  logic [15:0] sw_delay;
  logic [9:0]  sw_step;

  status_t expected_status[$];
  int      mismatches = 0;
  int      checked = 0;
  int      idle_cycles = 0;
  int      sent_beats = 0;
  int      live_beats = 0;
  int      step_loads = 0;
  bit      running_view = 1'b0;
  bit      source_steady = 1'b0;
  bit      sink_steady = 1'b0;

  function automatic logic [19:0] day_span(input logic [19:0] stop_t,
                                           input logic [19:0] origin_t,
                                           input logic [3:0] extra);
    return 20'((int'(stop_t) + int'(DAY_TENTHS) - int'(origin_t) + int'(extra))
               % int'(DAY_TENTHS));
  endfunction

  function automatic face_t time_fields(input logic [19:0] t);
    int    tv;
    face_t f;
    tv = int'(t);
    f.tenths = t;
    f.hours = 5'(tv / HOUR_TENTHS);
    f.minutes = 6'((tv % HOUR_TENTHS) / MINUTE_TENTHS);
    f.secs = 6'((tv % MINUTE_TENTHS) / SECOND_TENTHS);
    f.digit = 4'(tv % SECOND_TENTHS);
    return f;
  endfunction

  function automatic status_t advance_stopwatch(input logic [1:0] md,
                                                input logic [16:0] raw);
    logic [19:0] clock_t;
    int          amount;
    int          d;
    status_t     res;
    clock_t = 20'((int'(raw) % int'(DAY_SECONDS)) * 10);
    case (md)
      MODE_TICK: begin
        if (sw_active) begin
          sw_now = clock_t;
          sw_tick = sw_tick + 4'd1;
          if (sw_tick > TICK_TOP) begin
            d = int'(sw_delay) + int'(sw_step);
            sw_delay = (d > 65535) ? 16'hFFFF : 16'(d);
            sw_tick = TICK_TOP;
          end
          if (sw_now != sw_last) begin
            if (sw_first) begin
              sw_start = day_span(sw_start, 20'd0, TICK_TOP - sw_tick);
              sw_first = 1'b0;
            end else if (sw_tick < TICK_TOP) begin
              amount = int'(sw_step) * int'(TICK_TOP - sw_tick);
              sw_delay = (amount >= int'(sw_delay)) ? 16'd0 : 16'(int'(sw_delay) - amount);
            end
            sw_tick = 4'd0;
            sw_last = sw_now;
          end
        end
      end
      MODE_PRESS: begin
        if (!sw_active) begin
          sw_first = 1'b1;
          sw_tick = 4'd0;
          sw_start = clock_t;
          sw_last = clock_t;
          sw_now = clock_t;
        end
        sw_active = !sw_active;
      end
      MODE_LAP: begin
        if (sw_active) begin
          sw_lap = day_span(sw_last, sw_start, sw_tick);
        end
      end
      default: begin
      end
    endcase
    res.run = time_fields(day_span(sw_now, sw_start, sw_tick));
    res.lap = time_fields(sw_lap);
    res.running = sw_active;
    res.delay = sw_delay;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [19:0] want,
                                      input logic [19:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_status(input status_t want, input status_t got);
    check_field("elapsed_tenths", want.run.tenths, got.run.tenths);
    check_field("hours", want.run.hours, got.run.hours);
    check_field("minutes", want.run.minutes, got.run.minutes);
    check_field("secs", want.run.secs, got.run.secs);
    check_field("tenth_digit", want.run.digit, got.run.digit);
    check_field("lap_tenths", want.lap.tenths, got.lap.tenths);
    check_field("lap_hours", want.lap.hours, got.lap.hours);
    check_field("lap_minutes", want.lap.minutes, got.lap.minutes);
    check_field("lap_secs", want.lap.secs, got.lap.secs);
    check_field("lap_tenth_digit", want.lap.digit, got.lap.digit);
    check_field("running", want.running, got.running);
    check_field("tick_delay_ms", want.delay, got.delay);
  endfunction

  always @(posedge clk) begin : monitor_beats
    status_t seen;
    if (rst) begin
      sw_active = 1'b0;
      sw_first = 1'b0;
      sw_tick = 4'd0;
      sw_last = 20'd0;
      sw_start = 20'd0;
      sw_now = 20'd0;
      sw_lap = 20'd0;
      sw_delay = DELAY_RESET;
      sw_step = STEP_RESET;
    end else begin
      if (cfg_we) begin
        sw_step = cfg_wdata;
      end
      if (events_if.valid && events_if.ready) begin
        expected_status.push_back(advance_stopwatch(events_if.mode, events_if.rtc_seconds));
      end
      if (status_if.valid && status_if.ready) begin
        seen.run = '{status_if.elapsed_tenths, status_if.hours, status_if.minutes,
                     status_if.secs, status_if.tenth_digit};
        seen.lap = '{status_if.lap_tenths, status_if.lap_hours, status_if.lap_minutes,
                     status_if.lap_secs, status_if.lap_tenth_digit};
        seen.running = status_if.running;
        seen.delay = status_if.tick_delay_ms;
        if (expected_status.size() == 0) begin
          $display("%0t: status beat with no expectation waiting, elapsed %0d", $time,
                   seen.run.tenths);
          mismatches++;
        end else begin
          compare_status(expected_status.pop_front(), seen);
        end
        checked++;
      end
    end
    if ((events_if.valid && events_if.ready) || (status_if.valid && status_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    int stall;
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        status_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      status_if.ready <= 1'b1;
      @(posedge clk);
      while (!(status_if.valid === 1'b1 && status_if.ready)) @(posedge clk);
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_event(input logic [1:0] md, input int unsigned sec);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      events_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    events_if.valid <= 1'b1;
    events_if.mode <= md;
    events_if.rtc_seconds <= 17'(sec);
    @(posedge clk);
    while (!events_if.ready) @(posedge clk);
    if ((running_view && md != MODE_IDLE) || md == MODE_PRESS) begin
      live_beats++;
    end
    if (md == MODE_PRESS) begin
      running_view = !running_view;
    end
    sent_beats++;
  endtask

  task automatic settle_status();
    events_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic load_step(input logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_loads++;
  endtask

  task automatic test_stopped_events();
    send_event(MODE_TICK, 5);
    send_event(MODE_LAP, 0);
    send_event(MODE_IDLE, 131071);
  endtask

  task automatic test_first_second();
    settle_status();
    load_step(10'd1000);
    send_event(MODE_PRESS, 86399);
    repeat (3) send_event(MODE_TICK, 86399);
    send_event(MODE_TICK, 0);
    send_event(MODE_LAP, 0);
  endtask

  task automatic test_delay_limits();
    send_event(MODE_TICK, 1);
    send_event(MODE_TICK, 131071);
    repeat (10) send_event(MODE_TICK, 131071);
  endtask

  task automatic test_stop_restart();
    send_event(MODE_PRESS, 0);
    send_event(MODE_LAP, 7);
    send_event(MODE_PRESS, 100000);
  endtask

  task automatic test_random_sessions(input logic [9:0] step, input int beats,
                                      input bit steady, input bit long_first);
    logic [1:0]  noise_modes [3] = '{MODE_TICK, MODE_LAP, MODE_IDLE};
    int unsigned sec;
    int          goal;
    int          n;
    int          r;
    settle_status();
    load_step(step);
    source_steady = steady;
    sink_steady = steady;
    sec = ($urandom_range(0, 3) == 0) ? $urandom_range(86390, 86399) : $urandom_range(0, 86399);
    if (!running_view) begin
      send_event(MODE_PRESS, sec);
    end
    goal = live_beats + beats;
    while (live_beats < goal) begin
      r = $urandom_range(0, 99);
      if (long_first) begin
        n = 80;
        long_first = 1'b0;
      end else if (r < 70) begin
        n = $urandom_range(8, 11);
      end else if (r < 85) begin
        n = $urandom_range(0, 7);
      end else if (r < 96) begin
        n = $urandom_range(12, 20);
      end else begin
        n = $urandom_range(40, 80);
      end
      for (int k = 0; k < n; k++) begin
        send_event(MODE_TICK, sec);
        if ($urandom_range(0, 9) == 0) begin
          send_event(MODE_LAP, $urandom_range(0, 131071));
        end
        if ($urandom_range(0, 39) == 0) begin
          send_event(MODE_IDLE, $urandom_range(0, 131071));
        end
      end
      if ($urandom_range(0, 24) == 0) begin
        send_event(MODE_PRESS, $urandom_range(0, 131071));
        repeat ($urandom_range(0, 3)) begin
          send_event(noise_modes[$urandom_range(0, 2)], $urandom_range(0, 131071));
        end
        sec = ($urandom_range(0, 7) == 0) ? $urandom_range(86400, 131071)
                                          : $urandom_range(0, 86399);
        send_event(MODE_PRESS, sec);
      end
      r = $urandom_range(0, 99);
      if (r < 90) begin
        sec = (sec % DAY_SECONDS + 1) % DAY_SECONDS;
      end else if (r < 96) begin
        sec = $urandom_range(0, 86399);
      end else begin
        sec = $urandom_range(86400, 131071);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    events_if.valid <= 1'b0;
    events_if.mode <= MODE_TICK;
    events_if.rtc_seconds <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_stopped_events();
    test_first_second();
    test_delay_limits();
    test_stop_restart();

    test_random_sessions(10'd0, 150, 1'b1, 1'b0);
    test_random_sessions(10'd1023, 200, 1'b0, 1'b1);
    test_random_sessions(10'd1, 150, 1'b0, 1'b0);
    test_random_sessions(STEP_RESET, 200, 1'b1, 1'b0);
    test_random_sessions(10'($urandom_range(0, 1023)), 200, 1'b0, 1'b0);
    test_random_sessions(10'd1000, 200, 1'b0, 1'b0);

    settle_status();
    repeat (8) @(posedge clk);
    $display("Sent %0d event beats (%0d that change or press), %0d delay step loads.",
             sent_beats, live_beats, step_loads);
    $display("Compared %0d status beats, %0d field mismatches.", checked, mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/swti_pkg.sv
hw/rtl/swti_in_if.sv
hw/rtl/swti_out_if.sv
hw/rtl/swti_core.sv
hw/rtl/swti_split.sv
hw/rtl/stopwatch_tenths_interpolator.sv
tb/tb_stopwatch_tenths_interpolator.sv
